FILE: src/cdtu_pkg.sv
`default_nettype none
package cdtu_pkg;

	localparam logic [1:0] OPN_EXEC  = 2'd0;
	localparam logic [1:0] OPN_WRITE = 2'd1;
	localparam logic [1:0] OPN_READ  = 2'd2;

	localparam logic [2:0] RC_B = 3'd0;
	localparam logic [2:0] RC_C = 3'd1;
	localparam logic [2:0] RC_D = 3'd2;
	localparam logic [2:0] RC_E = 3'd3;
	localparam logic [2:0] RC_H = 3'd4;
	localparam logic [2:0] RC_L = 3'd5;
	localparam logic [2:0] RC_M = 3'd6;
	localparam logic [2:0] RC_A = 3'd7;

	localparam logic [4:0] FLAG_ALL = 5'h1F;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  opcode;
		logic [7:0]  operand_low;
		logic [7:0]  operand_high;
		logic [15:0] mem_address;
		logic [7:0]  mem_data;
		logic [7:0]  in_port_value;
	} cdtu_in_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [4:0]  cycles_used;
		logic        port_write;
		logic [7:0]  port_number;
		logic [7:0]  port_data;
		logic [7:0]  read_data;
		logic [7:0]  accumulator;
		logic        unsupported;
	} cdtu_out_t;

endpackage
`default_nettype wire

FILE: src/cdtu_chan_if.sv
`default_nettype none
interface cdtu_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/cpu8080_data_transfer_unit.sv
`default_nettype none
// channel | dir | payload
// in      | in  | operation, opcode, operands, mem_address, mem_data, in_port_value
// out     | out | next_pc, cycles_used, port flags, read_data, accumulator, unsupported
//
// an item is issued from the run state; each further byte-memory access
// (single port) takes its own step, and a read ending the item adds a step for its data;
// XTHL reads and writes two bytes, stepping through ACC1, ACC2 and ACC3
// register-only instructions and single-byte stores finish at issue, back to back
// a result waits in the output register; the next item is taken meanwhile
// unless that register is still full. reset clears the cpu and control registers, not memory
module cpu8080_data_transfer_unit #(
	parameter int ADDR_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	cdtu_chan_if.sink   in_ch,
	cdtu_chan_if.source out_ch
);
	import cdtu_pkg::*;

	localparam logic [2:0] ST_RUN  = 3'd0;
	localparam logic [2:0] ST_ACC1 = 3'd1;
	localparam logic [2:0] ST_ACC2 = 3'd2;
	localparam logic [2:0] ST_ACC3 = 3'd3;
	localparam logic [2:0] ST_ACC4 = 3'd4;

	logic [7:0]  acc_q;
	logic [7:0]  rb_q [6];
	logic [4:0]  flg_q;
	logic [15:0] sp_q, pc_q;
	logic [31:0] tot_q;
	logic [2:0]  st_q;
	cdtu_in_t    it_q;
	cdtu_out_t   res_q;
	logic        ov_q;

	logic                 m_we;
	logic [15:0]          m_a16;
	logic [7:0]           m_wd, m_rd;
	cdtu_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
		.clk(clk), .we(m_we), .addr(m_a16[ADDR_BITS-1:0]), .wdata(m_wd), .rdata(m_rd)
	);

	cdtu_in_t cur;
	assign cur = in_ch.payload;
	wire out_free = !ov_q || out_ch.ready;
	assign in_ch.ready  = (st_q == ST_RUN) && out_free;
	assign out_ch.valid = ov_q;
	assign out_ch.payload = res_q;
	wire take = in_ch.valid && in_ch.ready;

	// instruction classify, shared by issue and later steps
	function automatic logic [15:0] pr(input logic [7:0] h, input logic [7:0] l);
		return {h, l};
	endfunction

	logic [7:0] op;
	logic [2:0] dd, ss;
	logic [1:0] rp;
	logic is_mov, is_mvi, is_lxi, is_push, is_pop;
	always_comb begin
		op = (st_q == ST_RUN) ? cur.opcode : it_q.opcode;
		dd = op[5:3]; ss = op[2:0]; rp = op[5:4];
		is_mov  = (op[7:6] == 2'b01) && (op != 8'h76);
		is_mvi  = (op & 8'hC7) == 8'h06;
		is_lxi  = (op & 8'hCF) == 8'h01;
		is_push = (op & 8'hCF) == 8'hC5;
		is_pop  = (op & 8'hCF) == 8'hC1;
	end

	logic [7:0] rsrc;
	always_comb begin
		case (ss)
			RC_A:    rsrc = acc_q;
			RC_M:    rsrc = 8'h00;
			default: rsrc = rb_q[ss];
		endcase
	end
	wire [15:0] hl = pr(rb_q[4], rb_q[5]);
	wire [15:0] bc = pr(rb_q[0], rb_q[1]);
	wire [15:0] de = pr(rb_q[2], rb_q[3]);
	wire [15:0] dir_c = pr(cur.operand_high, cur.operand_low);
	wire [15:0] dir_q = pr(it_q.operand_high, it_q.operand_low);
	wire [7:0] ph = (rp == 2'd3) ? acc_q : rb_q[{rp, 1'b0}];
	wire [7:0] pl = (rp == 2'd3) ? {3'b0, flg_q & FLAG_ALL} : rb_q[{rp, 1'b1}];

	// memory port drive per step
	always_comb begin
		m_we = 1'b0; m_a16 = 16'h0; m_wd = 8'h00;
		case (st_q)
			ST_RUN: if (take) begin
				case (cur.operation)
					OPN_WRITE: begin m_we = 1'b1; m_a16 = cur.mem_address; m_wd = cur.mem_data; end
					OPN_READ: m_a16 = cur.mem_address;
					OPN_EXEC: begin
						if (is_mov && ss == RC_M) m_a16 = hl;
						else if (is_mov && dd == RC_M) begin m_we = 1'b1; m_a16 = hl; m_wd = rsrc; end
						else if (is_mvi && dd == RC_M) begin
							m_we = 1'b1; m_a16 = hl; m_wd = cur.operand_low;
						end else if (is_push) begin
							m_we = 1'b1; m_a16 = sp_q - 16'd1; m_wd = ph;
						end else if (is_pop || op == 8'hE3) m_a16 = sp_q;
						else if (op == 8'h02) begin m_we = 1'b1; m_a16 = bc; m_wd = acc_q; end
						else if (op == 8'h12) begin m_we = 1'b1; m_a16 = de; m_wd = acc_q; end
						else if (op == 8'h0A) m_a16 = bc;
						else if (op == 8'h1A) m_a16 = de;
						else if (op == 8'h32) begin m_we = 1'b1; m_a16 = dir_c; m_wd = acc_q; end
						else if (op == 8'h3A || op == 8'h2A) m_a16 = dir_c;
						else if (op == 8'h22) begin m_we = 1'b1; m_a16 = dir_c; m_wd = rb_q[5]; end
					end
					default: ;
				endcase
			end
			ST_ACC1: begin
				if (is_push) begin m_we = 1'b1; m_a16 = sp_q - 16'd1; m_wd = pl; end
				else if (is_pop) m_a16 = sp_q;
				else if (op == 8'h22) begin m_we = 1'b1; m_a16 = dir_q + 16'd1; m_wd = rb_q[4]; end
				else if (op == 8'h2A) m_a16 = dir_q + 16'd1;
				else if (op == 8'hE3) begin m_we = 1'b1; m_a16 = sp_q; m_wd = rb_q[5]; end
			end
			ST_ACC2: m_a16 = sp_q + 16'd1;
			ST_ACC3: begin m_we = 1'b1; m_a16 = sp_q + 16'd1; m_wd = rb_q[4]; end
			default: ;
		endcase
	end

	// execute sequencer
	logic [15:0] len;
	logic [4:0]  cyc;
	logic        uns, multi;
	always_comb begin
		len = 16'd1; cyc = 5'd0; uns = 1'b0; multi = 1'b0;
		if (is_mov) begin
			cyc = (dd == RC_M || ss == RC_M) ? 5'd7 : 5'd5; multi = (ss == RC_M);
		end else if (is_mvi) begin cyc = (dd == RC_M) ? 5'd10 : 5'd7; len = 16'd2; end
		else if (is_lxi) begin cyc = 5'd10; len = 16'd3; end
		else if (is_push) begin cyc = 5'd11; multi = 1'b1; end
		else if (is_pop) begin cyc = 5'd10; multi = 1'b1; end
		else begin
			case (op)
				8'h02, 8'h12: cyc = 5'd7;
				8'h0A, 8'h1A: begin cyc = 5'd7; multi = 1'b1; end
				8'h32: begin cyc = 5'd13; len = 16'd3; end
				8'h3A: begin cyc = 5'd13; len = 16'd3; multi = 1'b1; end
				8'h22, 8'h2A: begin cyc = 5'd16; len = 16'd3; multi = 1'b1; end
				8'hE3: begin cyc = 5'd18; multi = 1'b1; end
				8'hEB: cyc = 5'd4;
				8'hF9: cyc = 5'd5;
				8'hD3, 8'hDB: begin cyc = 5'd10; len = 16'd2; end
				default: uns = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; flg_q <= '0; sp_q <= '0; pc_q <= '0; tot_q <= '0;
			for (int i = 0; i < 6; i++) rb_q[i] <= '0;
			st_q <= ST_RUN; ov_q <= 1'b0;
		end else begin
			if (ov_q && out_ch.ready) ov_q <= 1'b0;
			case (st_q)
				ST_RUN: if (take) begin
					it_q <= cur;
					res_q <= '0;
					res_q.next_pc <= pc_q;
					res_q.accumulator <= acc_q;
					if (cur.operation == OPN_READ) st_q <= ST_ACC4;
					else if (cur.operation != OPN_EXEC) ov_q <= 1'b1;
					else begin
						res_q.unsupported <= uns;
						if (!uns) begin
							pc_q <= pc_q + len; tot_q <= tot_q + 32'(cyc);
							res_q.next_pc <= pc_q + len; res_q.cycles_used <= cyc;
						end
						if (multi) st_q <= ST_ACC1;
						else ov_q <= 1'b1;
						if (is_mov && dd != RC_M && ss != RC_M) begin
							if (dd == RC_A) begin acc_q <= rsrc; res_q.accumulator <= rsrc; end
							else rb_q[dd] <= rsrc;
						end else if (is_mvi && dd != RC_M) begin
							if (dd == RC_A) begin
								acc_q <= cur.operand_low; res_q.accumulator <= cur.operand_low;
							end else rb_q[dd] <= cur.operand_low;
						end else if (is_lxi) begin
							if (rp == 2'd3) sp_q <= dir_c;
							else begin rb_q[{rp, 1'b0}] <= cur.operand_high; rb_q[{rp, 1'b1}] <= cur.operand_low; end
						end else if (is_push) sp_q <= sp_q - 16'd1;
						else if (is_pop) sp_q <= sp_q + 16'd1;
						else if (op == 8'hEB) begin
							rb_q[2] <= rb_q[4]; rb_q[4] <= rb_q[2];
							rb_q[3] <= rb_q[5]; rb_q[5] <= rb_q[3];
						end else if (op == 8'hF9) sp_q <= hl;
						else if (op == 8'hD3) begin
							res_q.port_write <= 1'b1; res_q.port_number <= cur.operand_low;
							res_q.port_data <= acc_q;
						end else if (op == 8'hDB) begin
							res_q.port_number <= cur.operand_low;
							acc_q <= cur.in_port_value; res_q.accumulator <= cur.in_port_value;
						end
					end
				end
				// first access's data returns here
				ST_ACC1: begin
					st_q <= ST_RUN; ov_q <= 1'b1;
					if (is_mov) begin
						if (dd == RC_A) begin acc_q <= m_rd; res_q.accumulator <= m_rd; end
						else rb_q[dd] <= m_rd;
					end else if (is_push) sp_q <= sp_q - 16'd1;
					else if (is_pop) begin
						sp_q <= sp_q + 16'd1;
						if (rp == 2'd3) flg_q <= m_rd[4:0]; else rb_q[{rp, 1'b1}] <= m_rd;
						st_q <= ST_ACC2; ov_q <= 1'b0;
					end else if (op == 8'h0A || op == 8'h1A || op == 8'h3A) begin
						acc_q <= m_rd; res_q.accumulator <= m_rd;
					end else if (op == 8'h2A) begin
						rb_q[5] <= m_rd; st_q <= ST_ACC2; ov_q <= 1'b0;
					end else if (op == 8'hE3) begin
						rb_q[5] <= m_rd; st_q <= ST_ACC2; ov_q <= 1'b0;
					end
				end
				ST_ACC2: begin
					if (is_pop) begin
						st_q <= ST_RUN; ov_q <= 1'b1;
						if (rp == 2'd3) begin acc_q <= m_rd; res_q.accumulator <= m_rd; end
						else rb_q[{rp, 1'b0}] <= m_rd;
					end else if (op == 8'h2A) begin
						rb_q[4] <= m_rd; st_q <= ST_RUN; ov_q <= 1'b1;
					end else st_q <= ST_ACC3;
				end
				ST_ACC3: begin rb_q[4] <= m_rd; st_q <= ST_RUN; ov_q <= 1'b1; end
				ST_ACC4: begin res_q.read_data <= m_rd; st_q <= ST_RUN; ov_q <= 1'b1; end
				default: st_q <= ST_RUN;
			endcase
		end
	end

	// a held result is never overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ch.ready |=> ov_q && $stable(res_q))
		else $error("result lost while stalled");
	// input is only taken with the sequencer idle
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> st_q == ST_RUN)
		else $error("input taken mid-sequence");
	// from ACC2 the sequencer goes only to RUN or ACC3
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_ACC2 |=> st_q == ST_RUN || st_q == ST_ACC3)
		else $error("bad sequence step");
endmodule
`default_nettype wire

FILE: src/cdtu_mem.sv
`default_nettype none
module cdtu_mem #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] addr,
	input  wire logic [7:0]           wdata,
	output logic      [7:0]           rdata
);
	logic [7:0] mem [2**ADDR_BITS];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: tb/sv/cpu8080_data_transfer_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
import cdtu_pkg::*;

// predicts the data-transfer unit and checks its result stream
class cdtu_scoreboard;
	logic [7:0]  acc;
	logic [7:0]  bank [6];
	logic [4:0]  flags;
	logic [15:0] sp;
	logic [15:0] pc;
	logic [31:0] cyc_total;
	logic [7:0]  mem [logic [15:0]];
	cdtu_out_t   pending [$];
	int          errors;

	function new();
		acc = 0;
		flags = 0;
		sp = 0;
		pc = 0;
		cyc_total = 0;
		errors = 0;
		foreach (bank[i]) bank[i] = 0;
	endfunction

	function logic [7:0] rd(logic [15:0] a);
		return mem.exists(a) ? mem[a] : 8'h00;
	endfunction

	function logic [15:0] hl();
		return {bank[RC_H], bank[RC_L]};
	endfunction

	function logic [7:0] get_r(logic [2:0] c);
		if (c == RC_A) return acc;
		if (c == RC_M) return rd(hl());
		return bank[c];
	endfunction

	function void set_r(logic [2:0] c, logic [7:0] v);
		if (c == RC_A) acc = v;
		else if (c == RC_M) mem[hl()] = v;
		else bank[c] = v;
	endfunction

	function void push8(logic [7:0] v);
		sp = sp - 16'd1;
		mem[sp] = v;
	endfunction

	function logic [7:0] pop8();
		logic [7:0] v;
		v = rd(sp);
		sp = sp + 16'd1;
		return v;
	endfunction

	// note one accepted input transaction and queue its expected result
	function void note_input(cdtu_in_t t);
		cdtu_out_t   r;
		logic [7:0]  op;
		logic [1:0]  rp;
		logic [2:0]  d;
		logic [2:0]  s;
		logic [15:0] dir;
		logic [7:0]  tmp;
		int          len;
		op = t.opcode;
		rp = op[5:4];
		dir = {t.operand_high, t.operand_low};
		len = 1;
		r = '0;
		if (t.operation == OPN_WRITE) mem[t.mem_address] = t.mem_data;
		else if (t.operation == OPN_READ) r.read_data = rd(t.mem_address);
		else if (t.operation == OPN_EXEC) begin
			if (op >= 8'h40 && op <= 8'h7F && op != 8'h76) begin
				d = op[5:3];
				s = op[2:0];
				set_r(d, get_r(s));
				r.cycles_used = (d == RC_M || s == RC_M) ? 5'd7 : 5'd5;
			end else if ((op & 8'hC7) == 8'h06) begin
				d = op[5:3];
				set_r(d, t.operand_low);
				r.cycles_used = (d == RC_M) ? 5'd10 : 5'd7;
				len = 2;
			end else if ((op & 8'hCF) == 8'h01) begin
				if (rp == 3) sp = dir;
				else begin
					bank[rp*2] = t.operand_high;
					bank[rp*2+1] = t.operand_low;
				end
				r.cycles_used = 5'd10;
				len = 3;
			end else if ((op & 8'hCF) == 8'hC5) begin
				if (rp == 3) begin
					push8(acc);
					push8({3'b0, flags});
				end else begin
					push8(bank[rp*2]);
					push8(bank[rp*2+1]);
				end
				r.cycles_used = 5'd11;
			end else if ((op & 8'hCF) == 8'hC1) begin
				if (rp == 3) begin
					tmp = pop8();
					flags = tmp[4:0];
					acc = pop8();
				end else begin
					bank[rp*2+1] = pop8();
					bank[rp*2] = pop8();
				end
				r.cycles_used = 5'd10;
			end else begin
				case (op)
					8'h02: begin mem[{bank[RC_B], bank[RC_C]}] = acc; r.cycles_used = 5'd7; end
					8'h12: begin mem[{bank[RC_D], bank[RC_E]}] = acc; r.cycles_used = 5'd7; end
					8'h0A: begin acc = rd({bank[RC_B], bank[RC_C]}); r.cycles_used = 5'd7; end
					8'h1A: begin acc = rd({bank[RC_D], bank[RC_E]}); r.cycles_used = 5'd7; end
					8'h32: begin mem[dir] = acc; r.cycles_used = 5'd13; len = 3; end
					8'h3A: begin acc = rd(dir); r.cycles_used = 5'd13; len = 3; end
					8'h22: begin
						mem[dir] = bank[RC_L];
						mem[dir + 16'd1] = bank[RC_H];
						r.cycles_used = 5'd16;
						len = 3;
					end
					8'h2A: begin
						bank[RC_L] = rd(dir);
						bank[RC_H] = rd(dir + 16'd1);
						r.cycles_used = 5'd16;
						len = 3;
					end
					8'hE3: begin
						tmp = rd(sp);
						mem[sp] = bank[RC_L];
						bank[RC_L] = tmp;
						tmp = rd(sp + 16'd1);
						mem[sp + 16'd1] = bank[RC_H];
						bank[RC_H] = tmp;
						r.cycles_used = 5'd18;
					end
					8'hEB: begin
						tmp = bank[RC_D]; bank[RC_D] = bank[RC_H]; bank[RC_H] = tmp;
						tmp = bank[RC_E]; bank[RC_E] = bank[RC_L]; bank[RC_L] = tmp;
						r.cycles_used = 5'd4;
					end
					8'hF9: begin sp = hl(); r.cycles_used = 5'd5; end
					8'hD3: begin
						r.port_write = 1'b1;
						r.port_number = t.operand_low;
						r.port_data = acc;
						r.cycles_used = 5'd10;
						len = 2;
					end
					8'hDB: begin
						r.port_number = t.operand_low;
						acc = t.in_port_value;
						r.cycles_used = 5'd10;
						len = 2;
					end
					default: r.unsupported = 1'b1;
				endcase
			end
			if (!r.unsupported) begin
				pc = pc + 16'(len);
				cyc_total = cyc_total + 32'(r.cycles_used);
			end
		end
		r.next_pc = pc;
		r.accumulator = acc;
		pending.push_back(r);
	endfunction

	task report(string what, int got, int want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// compare one result transaction with the oldest expectation
	task check_result(cdtu_out_t g);
		cdtu_out_t e;
		if (pending.size() == 0) begin
			report("unexpected result transaction", 0, 0);
			return;
		end
		e = pending.pop_front();
		if (g.next_pc !== e.next_pc) report("next_pc", g.next_pc, e.next_pc);
		if (g.cycles_used !== e.cycles_used) report("cycles_used", g.cycles_used, e.cycles_used);
		if (g.port_write !== e.port_write) report("port_write", g.port_write, e.port_write);
		if (g.port_number !== e.port_number) report("port_number", g.port_number, e.port_number);
		if (g.port_data !== e.port_data) report("port_data", g.port_data, e.port_data);
		if (g.read_data !== e.read_data) report("read_data", g.read_data, e.read_data);
		if (g.accumulator !== e.accumulator) report("accumulator", g.accumulator, e.accumulator);
		if (g.unsupported !== e.unsupported) report("unsupported", g.unsupported, e.unsupported);
	endtask
endclass

module cpu8080_data_transfer_unit_tb;
	logic clk;
	logic arst_n;
	int   cycle_count;
	bit   calm;
	bit   hold_off;
	bit   stim_done;

	cdtu_chan_if #(.T(cdtu_in_t))  in_ch ();
	cdtu_chan_if #(.T(cdtu_out_t)) out_ch ();

	cpu8080_data_transfer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	cdtu_scoreboard sb = new();

	// memory bytes written so far; reads only touch these
	logic [15:0] known_addrs [$];

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("cpu8080_data_transfer_unit regression: fail");
			$finish;
		end
	end

	// sample input and result transactions at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.payload);
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
	end

	// receiver ready with random stall bursts and one long hold-off
	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) out_ch.ready <= 1'b0;
			else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 8);
				out_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
				out_ch.ready <= 1'b1;
			end else out_ch.ready <= 1'b1;
		end
	end

	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_off = 1'b1;
		repeat (200) @(posedge clk);
		hold_off = 1'b0;
	end

	// whether an address is safe to read
	function automatic bit is_known(logic [15:0] a);
		foreach (known_addrs[i]) if (known_addrs[i] == a) return 1;
		return 0;
	endfunction

	function automatic logic [15:0] pick_known();
		return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
	endfunction

	task automatic send(cdtu_in_t t);
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 8);
			in_ch.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_ch.payload <= t;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic mem_write(logic [15:0] a, logic [7:0] v);
		cdtu_in_t t;
		t = '0;
		t.operation = OPN_WRITE;
		t.mem_address = a;
		t.mem_data = v;
		t.opcode = 8'($urandom);
		t.in_port_value = 8'($urandom);
		if (!is_known(a)) known_addrs.push_back(a);
		send(t);
	endtask

	// make sure the bytes an opcode would read are written first
	task automatic prepare(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
		logic [15:0] a [$];
		logic [15:0] d;
		logic [15:0] hlv;
		d = {hi, lo};
		hlv = sb.hl();
		if (op >= 8'h40 && op <= 8'h7F && op[2:0] == RC_M) a.push_back(hlv);
		if (op == 8'h0A) a.push_back({sb.bank[RC_B], sb.bank[RC_C]});
		if (op == 8'h1A) a.push_back({sb.bank[RC_D], sb.bank[RC_E]});
		if (op == 8'h3A) a.push_back(d);
		if (op == 8'h2A) begin a.push_back(d); a.push_back(d + 16'd1); end
		if ((op & 8'hCF) == 8'hC1 || op == 8'hE3) begin
			a.push_back(sb.sp);
			a.push_back(sb.sp + 16'd1);
		end
		foreach (a[i]) if (!is_known(a[i])) mem_write(a[i], 8'($urandom));
	endtask

	task automatic exec(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
		cdtu_in_t t;
		prepare(op, lo, hi);
		t.operation = OPN_EXEC;
		t.opcode = op;
		t.operand_low = lo;
		t.operand_high = hi;
		t.mem_address = 16'($urandom);
		t.mem_data = 8'($urandom);
		t.in_port_value = 8'($urandom);
		// writes through the model must count as known bytes
		if (op >= 8'h40 && op <= 8'h7F && op[5:3] == RC_M && op != 8'h76 && !is_known(sb.hl()))
			known_addrs.push_back(sb.hl());
		if (op == 8'h36 && !is_known(sb.hl())) known_addrs.push_back(sb.hl());
		if (op == 8'h02 && !is_known({sb.bank[RC_B], sb.bank[RC_C]}))
			known_addrs.push_back({sb.bank[RC_B], sb.bank[RC_C]});
		if (op == 8'h12 && !is_known({sb.bank[RC_D], sb.bank[RC_E]}))
			known_addrs.push_back({sb.bank[RC_D], sb.bank[RC_E]});
		if (op == 8'h32 && !is_known({hi, lo})) known_addrs.push_back({hi, lo});
		if (op == 8'h22) begin
			if (!is_known({hi, lo})) known_addrs.push_back({hi, lo});
			if (!is_known({hi, lo} + 16'd1)) known_addrs.push_back({hi, lo} + 16'd1);
		end
		if ((op & 8'hCF) == 8'hC5) begin
			if (!is_known(sb.sp - 16'd1)) known_addrs.push_back(sb.sp - 16'd1);
			if (!is_known(sb.sp - 16'd2)) known_addrs.push_back(sb.sp - 16'd2);
		end
		send(t);
	endtask

	task automatic mem_read(logic [15:0] a, logic [1:0] opn);
		cdtu_in_t t;
		t = '0;
		t.operation = opn;
		t.mem_address = a;
		t.mem_data = 8'($urandom);
		t.opcode = 8'($urandom);
		t.operand_low = 8'($urandom);
		t.operand_high = 8'($urandom);
		t.in_port_value = 8'($urandom);
		send(t);
	endtask

	// a pick that favors the transfer group, now and then any byte
	function automatic logic [7:0] pick_opcode();
		logic [7:0] grp [] = '{8'h02, 8'h12, 8'h0A, 8'h1A, 8'h32, 8'h3A, 8'h22, 8'h2A,
			8'hE3, 8'hEB, 8'hF9, 8'hD3, 8'hDB, 8'hC5, 8'hD5, 8'hE5, 8'hF5,
			8'hC1, 8'hD1, 8'hE1, 8'hF1, 8'h01, 8'h11, 8'h21, 8'h31};
		int k;
		k = $urandom_range(0, 9);
		if (k < 4) return 8'h40 + 8'($urandom_range(0, 63));
		if (k < 5) return {2'b00, 3'($urandom), 3'b110};
		if (k < 9) return grp[$urandom_range(0, grp.size() - 1)];
		return 8'($urandom);
	endfunction

	initial begin
		int k;
		logic [7:0] op;
		arst_n = 1'b0;
		calm = 1'b0;
		stim_done = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, stack wrap, psw, hlt and undefined operation
		mem_write(16'hFFFF, 8'hFF);
		mem_write(16'h0000, 8'h00);
		mem_read(16'hFFFF, OPN_READ);
		mem_read(16'h0000, OPN_READ);
		mem_read(16'hFFFF, 2'd3);
		exec(8'h3E, 8'hFF, 8'h00);
		exec(8'h31, 8'h00, 8'h00);
		exec(8'hF5, 8'h00, 8'h00);
		exec(8'hC5, 8'h00, 8'h00);
		exec(8'hF1, 8'h00, 8'h00);
		exec(8'hE3, 8'h00, 8'h00);
		exec(8'h21, 8'hFF, 8'hFF);
		exec(8'h22, 8'hFF, 8'hFF);
		exec(8'h2A, 8'hFF, 8'hFF);
		exec(8'hEB, 8'h00, 8'h00);
		exec(8'hF9, 8'h00, 8'h00);
		exec(8'hD3, 8'hFF, 8'h00);
		exec(8'hDB, 8'h00, 8'h00);
		exec(8'hDB, 8'hFF, 8'hFF);
		exec(8'h76, 8'h00, 8'h00);
		exec(8'hFF, 8'hFF, 8'hFF);
		exec(8'h00, 8'h00, 8'h00);
		exec(8'h77, 8'h00, 8'h00);

		// random traffic, mostly instructions
		for (int i = 0; i < 1850; i++) begin
			if (i > 1600) calm = 1'b1;
			k = $urandom_range(0, 9);
			if (k == 0) mem_write(16'($urandom), 8'($urandom));
			else if (k == 1) mem_read(pick_known(), OPN_READ);
			else if (k == 2 && $urandom_range(0, 3) == 0) mem_read(pick_known(), 2'd3);
			else begin
				op = pick_opcode();
				exec(op, 8'($urandom), 8'($urandom));
			end
		end
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;

		// drain and settle
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) $display("cpu8080_data_transfer_unit regression: pass");
		else $display("cpu8080_data_transfer_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

FILE: cpu8080_data_transfer_unit.f
src/cdtu_pkg.sv
src/cdtu_chan_if.sv
src/cdtu_mem.sv
src/cpu8080_data_transfer_unit.sv
tb/sv/cpu8080_data_transfer_unit_tb.sv
